// ===== rtl/ssbm_pkg.sv =====
// Shared constants, codes and control types of the stereo SAD block matcher.
package ssbm_pkg;
	localparam int MAX_WIDTH_DEF      = 1024;
	localparam int MAX_HALF_BLOCK_DEF = 7;
	localparam int MAX_DISPARITY_DEF  = 64;
	localparam int MAX_HEIGHT         = 4096;
	localparam int SW                 = 16;   // signed width for window bounds
	localparam int CFG_IW             = 3;
	localparam int CFG_DW             = 13;
	localparam int ROW_W              = 12;

	localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_MIN_DISPARITY = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_MAX_DISPARITY = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_HALF_BLOCK    = 3'd4;

	typedef struct packed {
		logic accept;
		logic start;
		logic issue;
		logic load_out;
	} ssbm_ctrl_t;

	typedef struct packed {
		logic go;
		logic last_issue;
		logic done;
		logic out_full;
	} ssbm_stat_t;
endpackage

// ===== rtl/ssbm_in_if.sv =====
// Input channel carrying one left and right pixel pair per item.
interface ssbm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] left_pixel;
	logic [7:0] right_pixel;
	modport source (output valid, output left_pixel, output right_pixel, input ready);
	modport sink (input valid, input left_pixel, input right_pixel, output ready);
endinterface

// ===== rtl/ssbm_out_if.sv =====
// Output channel carrying one disparity result per item.
interface ssbm_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] out_row;
	logic [10:0] out_col;
	logic [5:0]  best_offset;
	logic [15:0] best_sad;
	modport source (output valid, output out_row, output out_col, output best_offset,
		output best_sad, input ready);
	modport sink (input valid, input out_row, input out_col, input best_offset,
		input best_sad, output ready);
endinterface

// ===== rtl/stereo_sad_block_matcher.sv =====
// Top level of the stereo SAD block matcher: controller plus datapath.
// An item that completes a block is accepted in IDLE, checked in EVAL, scanned in RUN over
// every offset, row and column of its (2h)x(2h) window, drained, and loaded into the output
// register in FINISH once that register is empty. The scan reads one pixel pair of each line
// store a cycle. No new item is accepted until the controller is back in IDLE.
// A finished result waits in the output register while the next item is accepted.
// Reset (arst_n low) clears the state machine, the raster counters and the valid flags and loads
// the register defaults; the line stores are not cleared and need no clearing pass.
module stereo_sad_block_matcher import ssbm_pkg::*; #(
	parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
	parameter int MAX_HALF_BLOCK = MAX_HALF_BLOCK_DEF,
	parameter int MAX_DISPARITY  = MAX_DISPARITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	ssbm_in_if.sink           in_ch,
	ssbm_out_if.source        out_ch
);
	// Command and status signals between the controller and the datapath.
	ssbm_ctrl_t ctrl;
	ssbm_stat_t stat;

	// The controller takes one item at a time, checks whether it completes a block, and
	// then steps the datapath through every offset, row and column of that block.
	ssbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	// The datapath holds the line stores, the SAD accumulator and the result register.
	ssbm_datapath #(
		.MAX_WIDTH      (MAX_WIDTH),
		.MAX_HALF_BLOCK (MAX_HALF_BLOCK),
		.MAX_DISPARITY  (MAX_DISPARITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctrl      (ctrl),
		.stat      (stat),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);
endmodule

// ===== rtl/ssbm_ctrl.sv =====
// Controller state machine that sequences write, window check, SAD scan and result load.
module ssbm_ctrl import ssbm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ssbm_stat_t stat,
	output ssbm_ctrl_t ctrl
);
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EVAL   = 5'b00010,
		ST_RUN    = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		ctrl          = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.accept = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (stat.go) begin
					ctrl.start = 1'b1;
					state_d    = ST_RUN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_RUN: begin
				ctrl.issue = 1'b1;
				if (stat.last_issue) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (stat.done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!stat.out_full) begin
					ctrl.load_out = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== rtl/ssbm_datapath.sv =====
// Datapath: configuration, raster counters, line stores, SAD accumulator and result register.
module ssbm_datapath import ssbm_pkg::*; #(
	parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
	parameter int MAX_HALF_BLOCK = MAX_HALF_BLOCK_DEF,
	parameter int MAX_DISPARITY  = MAX_DISPARITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  ssbm_ctrl_t        ctrl,
	output ssbm_stat_t        stat,
	ssbm_in_if.sink           in_ch,
	ssbm_out_if.source        out_ch
);
	localparam int S   = 2 * MAX_HALF_BLOCK;
	localparam int RMW = (S > 1) ? $clog2(S) : 1;
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HALF_BLOCK + 1);
	localparam int XW  = $clog2(S);
	localparam int AW  = $clog2(S * MAX_WIDTH);

	// Configuration registers.
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [5:0]  dmin_q;
	logic [6:0]  dmaxr_q;
	logic [2:0]  half_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 13'd480;
			dmin_q   <= 6'd0;
			dmaxr_q  <= 7'd32;
			half_q   <= 3'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:   width_q  <= cfg_data[10:0];
				CFG_IMAGE_HEIGHT:  height_q <= cfg_data;
				CFG_MIN_DISPARITY: dmin_q   <= cfg_data[5:0];
				CFG_MAX_DISPARITY: dmaxr_q  <= cfg_data[6:0];
				CFG_HALF_BLOCK:    half_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Clamped working values.
	logic [WW-1:0] w;
	logic [12:0]   ht;
	logic [HW-1:0] h;
	logic [6:0]    dmax;
	assign w    = (width_q == '0) ? WW'(1) :
		((32'(width_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_q));
	assign ht   = (height_q == '0) ? 13'd1 :
		((32'(height_q) > MAX_HEIGHT) ? 13'(MAX_HEIGHT) : height_q);
	assign h    = (half_q == '0) ? HW'(1) :
		((32'(half_q) > MAX_HALF_BLOCK) ? HW'(MAX_HALF_BLOCK) : HW'(half_q));
	assign dmax = (32'(dmaxr_q) > MAX_DISPARITY) ? 7'(MAX_DISPARITY) : dmaxr_q;

	// Raster counters, with the row also tracked modulo the store depth.
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_q;
	logic [RMW-1:0]   rmod_q;
	logic [ROW_W-1:0] r_cur;
	logic [CW-1:0]    c_cur;
	logic [RMW-1:0]   rm_cur;
	logic [CW:0]      c_inc;
	logic [ROW_W:0]   r_inc;

	assign r_cur  = (13'(row_q) >= ht) ? '0 : row_q;
	assign rm_cur = (13'(row_q) >= ht) ? '0 : rmod_q;
	assign c_cur  = (WW'(col_q) >= w) ? '0 : col_q;
	assign c_inc  = {1'b0, c_cur} + (CW+1)'(1);
	assign r_inc  = {1'b0, r_cur} + (ROW_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			rmod_q <= '0;
		end else if (ctrl.accept) begin
			if (WW'(c_inc) >= w) begin
				col_q <= '0;
				if (13'(r_inc) >= ht) begin
					row_q  <= '0;
					rmod_q <= '0;
				end else begin
					row_q  <= r_inc[ROW_W-1:0];
					rmod_q <= (32'(rm_cur) == S - 1) ? '0 : rm_cur + RMW'(1);
				end
			end else begin
				col_q  <= c_inc[CW-1:0];
				row_q  <= r_cur;
				rmod_q <= rm_cur;
			end
		end
	end

	// Position of the accepted item.
	logic [ROW_W-1:0] rr_q;
	logic [CW-1:0]    cc_q;
	logic [RMW-1:0]   rm_q;
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			rr_q <= r_cur;
			cc_q <= c_cur;
			rm_q <= rm_cur;
		end
	end

	// Window check.
	logic signed [SW-1:0] bi, bj, hs, dms, ws, hts;
	assign hs  = SW'(h);
	assign dms = SW'(dmax);
	assign ws  = SW'(w);
	assign hts = SW'(ht);
	assign bi  = SW'(rr_q) - hs + SW'(1);
	assign bj  = SW'(cc_q) - hs - dms + SW'(2);
	assign stat.go = (7'(dmin_q) < dmax) && (bi >= hs) && (bi <= hts - hs - SW'(1)) &&
		(bj >= hs) && (bj <= ws - hs - dms - SW'(1));

	// First store row of the window, modulo the store depth.
	logic [RMW:0] top_sum;
	logic [RMW:0] top_row;
	assign top_sum = {1'b0, rm_q} + (RMW+1)'(S) - (RMW+1)'(2 * 32'(h) - 1);
	assign top_row = (32'(top_sum) >= S) ? top_sum - (RMW+1)'(S) : top_sum;

	// Scan counters: offset outer, row, column inner.
	logic [XW-1:0]  x_q, y_q, side_m1;
	logic [RMW-1:0] ry_q, top_q;
	logic [6:0]     d_q;
	logic [CW-1:0]  lc_q;
	logic           last_x, last_y, last_d;
	assign side_m1 = XW'(2 * 32'(h) - 1);
	assign last_x  = (x_q == side_m1);
	assign last_y  = (y_q == side_m1);
	assign last_d  = (d_q == dmax - 7'd1);
	assign stat.last_issue = last_x && last_y && last_d;

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			d_q   <= 7'(dmin_q);
			x_q   <= '0;
			y_q   <= '0;
			ry_q  <= top_row[RMW-1:0];
			top_q <= top_row[RMW-1:0];
			lc_q  <= CW'(bj - hs);
		end else if (ctrl.issue) begin
			if (last_x) begin
				x_q <= '0;
				if (last_y) begin
					y_q  <= '0;
					ry_q <= top_q;
					d_q  <= d_q + 7'd1;
				end else begin
					y_q  <= y_q + XW'(1);
					ry_q <= (32'(ry_q) == S - 1) ? '0 : ry_q + RMW'(1);
				end
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
	end

	// Line stores: written on accept, read during the scan.
	logic [7:0]       lmem [S*MAX_WIDTH];
	logic [7:0]       rmem [S*MAX_WIDTH];
	logic [7:0]       ldat_q, rdat_q;
	logic [AW-1:0]    waddr, laddr, raddr;
	logic [CW+8:0]    lcol, rcol;
	assign waddr = AW'(rm_cur) * AW'(MAX_WIDTH) + AW'(c_cur);
	assign lcol  = (CW+9)'(lc_q) + (CW+9)'(x_q);
	assign rcol  = lcol + (CW+9)'(d_q);
	assign laddr = AW'(ry_q) * AW'(MAX_WIDTH) + AW'(lcol);
	assign raddr = AW'(ry_q) * AW'(MAX_WIDTH) + AW'(rcol);

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			lmem[waddr] <= in_ch.left_pixel;
			rmem[waddr] <= in_ch.right_pixel;
		end
		ldat_q <= lmem[laddr];
		rdat_q <= rmem[raddr];
	end

	// Tags that travel with each read.
	logic       v_s1, lastpix_s1, lastd_s1;
	logic [6:0] d_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= ctrl.issue;
	end
	always_ff @(posedge clk) begin
		lastpix_s1 <= last_x && last_y;
		lastd_s1   <= last_d;
		d_s1       <= d_q;
	end

	// Accumulate and keep the best offset; the first offset always loads.
	logic [7:0]  diff;
	logic [15:0] sum;
	logic [15:0] acc_q, best_sad_q;
	logic [6:0]  best_d_q;
	logic        first_q, done_q;
	assign diff = (ldat_q > rdat_q) ? ldat_q - rdat_q : rdat_q - ldat_q;
	assign sum  = acc_q + 16'(diff);
	assign stat.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			first_q <= 1'b1;
		end else if (ctrl.start) begin
			done_q  <= 1'b0;
			first_q <= 1'b1;
		end else if (v_s1 && lastpix_s1) begin
			first_q <= 1'b0;
			if (lastd_s1) done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			acc_q <= '0;
		end else if (v_s1) begin
			if (lastpix_s1) begin
				acc_q <= '0;
				if (first_q || sum < best_sad_q) begin
					best_sad_q <= sum;
					best_d_q   <= d_s1;
				end
			end else begin
				acc_q <= sum;
			end
		end
	end

	// Result register.
	logic        ovalid_q;
	logic [11:0] orow_q;
	logic [10:0] ocol_q;
	logic [5:0]  ooff_q;
	logic [15:0] osad_q;
	assign stat.out_full = ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (ctrl.load_out) ovalid_q <= 1'b1;
		else if (out_ch.ready) ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			orow_q <= bi[11:0];
			ocol_q <= 11'(bj + dms);
			ooff_q <= best_d_q[5:0];
			osad_q <= best_sad_q;
		end
	end

	assign out_ch.valid       = ovalid_q;
	assign out_ch.out_row     = orow_q;
	assign out_ch.out_col     = ocol_q;
	assign out_ch.best_offset = ooff_q;
	assign out_ch.best_sad    = osad_q;
endmodule

// ===== tb/sv/tb_stereo_sad_block_matcher.sv =====
// Self-checking testbench for the stereo SAD block matcher, with scoreboard and stream drivers.
module tb_stereo_sad_block_matcher;
	import ssbm_pkg::*;

	// The cycle limit sits far above the slowest legal run of this stimulus, even if every item
	// completed a block with the longest scan and the longest stalls.
	localparam int CYCLE_LIMIT = 4000000;
	// Cycles allowed for an item that completes no block to finish before a register write.
	localparam int SETTLE = 16;
	localparam int STORE_ROWS = 2 * MAX_HALF_BLOCK_DEF;

	typedef struct {
		logic [11:0] row;
		logic [10:0] col;
		logic [5:0]  offset;
		logic [15:0] sad;
	} match_t;

	// The scoreboard keeps its own copy of the registers, the line stores and the raster
	// position. Every accepted pixel pair goes through disparity_search, which queues a match
	// whenever that pair completes a block.
	class match_scoreboard;
		logic [10:0] width_reg;
		logic [12:0] height_reg;
		logic [5:0]  dmin_reg;
		logic [6:0]  dmax_reg;
		logic [2:0]  half_reg;
		logic [7:0]  left_store [STORE_ROWS*MAX_WIDTH_DEF];
		logic [7:0]  right_store [STORE_ROWS*MAX_WIDTH_DEF];
		int          row_pos;
		int          col_pos;
		match_t      pending_matches [$];
		int          errors;
		int          matches_seen;

		function new();
			width_reg  = 11'd640;
			height_reg = 13'd480;
			dmin_reg   = 6'd0;
			dmax_reg   = 7'd32;
			half_reg   = 3'd3;
			row_pos    = 0;
			col_pos    = 0;
			errors     = 0;
			matches_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
			case (idx)
				CFG_IMAGE_WIDTH:   width_reg  = data[10:0];
				CFG_IMAGE_HEIGHT:  height_reg = data;
				CFG_MIN_DISPARITY: dmin_reg   = data[5:0];
				CFG_MAX_DISPARITY: dmax_reg   = data[6:0];
				CFG_HALF_BLOCK:    half_reg   = data[2:0];
				default: ;
			endcase
		endfunction

		function int addr(int row, int col);
			return (row % STORE_ROWS) * MAX_WIDTH_DEF + (col % MAX_WIDTH_DEF);
		endfunction

		// Notes one accepted pixel pair and predicts the match it completes, if any.
		function void disparity_search(logic [7:0] lpix, logic [7:0] rpix);
			int w, ht, hb, dmax, dmin, r, c, bi, bj, side, best_d, best_s, sad, lp, rp;
			match_t m;
			w    = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : width_reg);
			ht   = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
			hb   = (half_reg == 0) ? 1 : half_reg;
			dmax = (dmax_reg > MAX_DISPARITY_DEF) ? MAX_DISPARITY_DEF : dmax_reg;
			dmin = dmin_reg;
			r = (row_pos >= ht) ? 0 : row_pos;
			c = (col_pos >= w) ? 0 : col_pos;
			left_store[addr(r, c)]  = lpix;
			right_store[addr(r, c)] = rpix;
			bi = r - hb + 1;
			bj = c - hb - dmax + 2;
			if (dmin < dmax && bi >= hb && bi <= ht - hb - 1 && bj >= hb &&
					bj <= w - hb - dmax - 1) begin
				side   = 2 * hb;
				best_d = dmin;
				best_s = -1;
				for (int d = dmin; d < dmax; d++) begin
					sad = 0;
					for (int y = 0; y < side; y++)
						for (int x = 0; x < side; x++) begin
							lp = left_store[addr(bi - hb + y, bj - hb + x)];
							rp = right_store[addr(bi - hb + y, bj - hb + x + d)];
							sad += (lp > rp) ? lp - rp : rp - lp;
						end
					// Strictly smaller only, so the smallest offset keeps a tie.
					if (best_s < 0 || sad < best_s) begin
						best_s = sad;
						best_d = d;
					end
				end
				m.row    = bi[11:0];
				m.col    = 11'(bj + dmax);
				m.offset = best_d[5:0];
				m.sad    = best_s[15:0];
				pending_matches.push_back(m);
			end
			c++;
			if (c >= w) begin
				c = 0;
				r++;
				if (r >= ht) r = 0;
			end
			col_pos = c;
			row_pos = r;
		endfunction

		function void check_match(match_t got);
			match_t exp;
			if (pending_matches.size() == 0) begin
				$display("%0t: unexpected match row %0d col %0d offset %0d sad %0d", $time,
					got.row, got.col, got.offset, got.sad);
				errors++;
				return;
			end
			exp = pending_matches.pop_front();
			matches_seen++;
			if (got.row !== exp.row) begin
				$display("%0t: out_row expected %0d actual %0d", $time, exp.row, got.row);
				errors++;
			end
			if (got.col !== exp.col) begin
				$display("%0t: out_col expected %0d actual %0d", $time, exp.col, got.col);
				errors++;
			end
			if (got.offset !== exp.offset) begin
				$display("%0t: best_offset expected %0d actual %0d", $time, exp.offset,
					got.offset);
				errors++;
			end
			if (got.sad !== exp.sad) begin
				$display("%0t: best_sad expected %0d actual %0d", $time, exp.sad, got.sad);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_IW-1:0]   cfg_index;
	logic [CFG_DW-1:0]   cfg_data;
	int                  cycles;
	int                  pairs_sent;
	int                  images_sent;
	// When calm is set, neither side inserts idle cycles, so back-to-back streaming is seen.
	bit                  calm;
	match_scoreboard     sb;

	ssbm_in_if  pix_ch ();
	ssbm_out_if match_ch ();

	stereo_sad_block_matcher DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (pix_ch.sink),
		.out_ch    (match_ch.source)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Global watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: before each result the receiver holds ready low for a random number of
	// cycles, then keeps it high until a match is taken. The match is checked on that edge.
	initial begin
		int     stall;
		match_t got;
		match_ch.ready <= 1'b0;
		@(posedge clk);
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				match_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			match_ch.ready <= 1'b1;
			do @(posedge clk); while (!(match_ch.valid === 1'b1 && match_ch.ready === 1'b1));
			got.row    = match_ch.out_row;
			got.col    = match_ch.out_col;
			got.offset = match_ch.best_offset;
			got.sad    = match_ch.best_sad;
			sb.check_match(got);
		end
	end

	// Sends one pixel pair after a random gap. Valid is left high after acceptance, so a
	// following item with no gap keeps it high throughout.
	task automatic send_pair(logic [7:0] lpix, logic [7:0] rpix);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.left_pixel  <= lpix;
		pix_ch.right_pixel <= rpix;
		do @(posedge clk); while (!(pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1));
		sb.disparity_search(lpix, rpix);
		pairs_sent++;
	endtask

	// Holds the sender until every predicted match has arrived, then lets the block settle, so
	// that register writes only ever happen while it is idle.
	task automatic drain;
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_matches.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write enable stays high between consecutive writes; configure drops it after the last one.
	task automatic write_reg(logic [CFG_IW-1:0] idx, int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DW-1:0];
		@(posedge clk);
		sb.write_reg(idx, value[CFG_DW-1:0]);
	endtask

	// Reconfigures the idle block. Width and height are raw register values, so zero and
	// oversized values exercise the clamping.
	task automatic configure(int w, int ht, int dmin, int dmax, int hb);
		drain();
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, ht);
		write_reg(CFG_MIN_DISPARITY, dmin);
		write_reg(CFG_MAX_DISPARITY, dmax);
		write_reg(CFG_HALF_BLOCK, hb);
		cfg_we <= 1'b0;
		calm = ($urandom_range(0, 4) == 0);
	endtask

	// Streams one whole image so that the raster position is back at the origin afterwards.
	// Style 0 is uniform noise, 1 is a right image close to the left one, 2 is black and
	// white only, 3 is a white left image over a black right image, giving the largest SAD.
	task automatic send_image(int w, int ht, int style);
		logic [7:0] lpix, rpix;
		for (int n = 0; n < w * ht; n++) begin
			lpix = $urandom_range(0, 255);
			case (style)
				0: rpix = $urandom_range(0, 255);
				1: rpix = lpix + 8'($urandom_range(0, 3));
				2: begin
					lpix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					rpix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				end
				default: begin
					lpix = 8'hFF;
					rpix = 8'h00;
				end
			endcase
			send_pair(lpix, rpix);
		end
		images_sent++;
	endtask

	initial begin
		int hb, dmax, dmin, w, ht;
		sb          = new();
		cycles      = 0;
		pairs_sent  = 0;
		images_sent = 0;
		calm        = 1'b0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_IMAGE_WIDTH;
		cfg_data    = '0;
		pix_ch.valid       = 1'b0;
		pix_ch.left_pixel  = 8'h00;
		pix_ch.right_pixel = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The smallest legal block and search range, on black and white pixels.
		configure(8, 3, 0, 1, 1);
		send_image(8, 3, 2);
		// The largest block over a white-on-black pair gives the largest possible SAD.
		configure(16, 15, 0, 1, 7);
		send_image(16, 15, 3);
		// An empty search range, equal and inverted, produces no match at all.
		configure(10, 4, 5, 5, 1);
		send_image(10, 4, 0);
		configure(10, 4, 9, 3, 1);
		send_image(10, 4, 0);
		// The largest minimum offset with an oversized maximum that clamps to the limit.
		configure(70, 3, 63, 127, 1);
		send_image(70, 3, 0);
		// Zero width, zero height and zero half block all clamp to one.
		configure(0, 5, 0, 1, 1);
		send_image(1, 5, 0);
		configure(5, 0, 0, 1, 0);
		send_image(5, 1, 0);
		configure(6, 3, 0, 2, 0);
		send_image(6, 3, 1);
		// A wide image with the full search range, one block row deep.
		configure(72, 3, 0, 64, 1);
		send_image(72, 3, 1);

		// Random part: small images with random geometry, most with a searchable range.
		while (pairs_sent < 1050) begin
			hb   = $urandom_range(1, 3);
			dmax = $urandom_range(1, 8);
			dmin = ($urandom_range(0, 9) == 0) ? $urandom_range(dmax, 63)
				: $urandom_range(0, dmax - 1);
			w    = 2 * hb + dmax + 1 + $urandom_range(0, 6);
			ht   = 2 * hb + 1 + $urandom_range(0, 3);
			configure(w, ht, dmin, dmax, hb);
			send_image(w, ht, $urandom_range(0, 3) == 0 ? 2 : $urandom_range(0, 1));
		end

		drain();
		$display("Sent %0d pixel pairs in %0d images and checked %0d matches,", pairs_sent,
			images_sent, sb.matches_seen);
		$display("covering clamped registers, empty ranges, the largest block and full search.");
		if (sb.errors == 0 && sb.pending_matches.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/ssbm_pkg.sv
rtl/ssbm_in_if.sv
rtl/ssbm_out_if.sv
rtl/ssbm_ctrl.sv
rtl/ssbm_datapath.sv
rtl/stereo_sad_block_matcher.sv
tb/sv/tb_stereo_sad_block_matcher.sv
